// File: design/uom_pkg.sv
package uom_pkg;

    // quarter-wave sine polynomial coefficients, Q14
    localparam int SIN_A = 25736;
    localparam int SIN_B = 10583;
    localparam int SIN_C = 1232;

    localparam logic [31:0] LFSR_TAPS = 32'hD000_0001;
    localparam logic [31:0] LFSR_SEED = 32'h0000_ACE1;

    // datapath widths
    localparam int DIV_W = 40;   // divider dividend magnitude
    localparam int ACC_W = 38;   // stereo accumulators and multiplier A operand
    localparam int L_W   = 24;   // channel values after scaling

    // request codes
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_BLOCK = 2'd1;
    localparam logic [1:0] REQ_LOAD  = 2'd2;
    localparam logic [1:0] REQ_NOTE  = 2'd3;

    // wave codes
    localparam logic [2:0] WAVE_SINE     = 3'd0;
    localparam logic [2:0] WAVE_SAW      = 3'd1;
    localparam logic [2:0] WAVE_SQUARE   = 3'd2;
    localparam logic [2:0] WAVE_TRIANGLE = 3'd3;
    localparam logic [2:0] WAVE_NOISE    = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_WAVE   = 3'd0;
    localparam logic [2:0] CFG_VOICES = 3'd1;
    localparam logic [2:0] CFG_AMP    = 3'd2;
    localparam logic [2:0] CFG_SPREAD = 3'd3;
    localparam logic [2:0] CFG_ATTACK = 3'd4;

    typedef enum logic [25:0] {
        S_IDLE     = 26'(1) << 0,
        S_BB       = 26'(1) << 1,
        S_BB_WR    = 26'(1) << 2,
        S_INC      = 26'(1) << 3,
        S_WAVE     = 26'(1) << 4,
        S_AMP      = 26'(1) << 5,
        S_PAN      = 26'(1) << 6,
        S_PAN_WR   = 26'(1) << 7,
        S_GR       = 26'(1) << 8,
        S_GL       = 26'(1) << 9,
        S_ML       = 26'(1) << 10,
        S_MR       = 26'(1) << 11,
        S_FL       = 26'(1) << 12,
        S_FR       = 26'(1) << 13,
        S_ATT_L    = 26'(1) << 14,
        S_ATT_L_WR = 26'(1) << 15,
        S_ATT_R    = 26'(1) << 16,
        S_ATT_R_WR = 26'(1) << 17,
        S_ENV_L    = 26'(1) << 18,
        S_ENV_R    = 26'(1) << 19,
        S_OUT      = 26'(1) << 20,
        S_Q1       = 26'(1) << 21,
        S_Q2       = 26'(1) << 22,
        S_Q3       = 26'(1) << 23,
        S_Q4       = 26'(1) << 24,
        S_DIV      = 26'(1) << 25
    } state_t;

    // 1/sqrt(n+1), Q15
    function automatic logic [16:0] inv_sqrt(input logic [3:0] idx);
        logic [16:0] g;
        unique case (idx)
            4'd0:  g = 17'd32768;
            4'd1:  g = 17'd23170;
            4'd2:  g = 17'd18919;
            4'd3:  g = 17'd16384;
            4'd4:  g = 17'd14654;
            4'd5:  g = 17'd13378;
            4'd6:  g = 17'd12385;
            4'd7:  g = 17'd11585;
            4'd8:  g = 17'd10923;
            4'd9:  g = 17'd10362;
            4'd10: g = 17'd9880;
            4'd11: g = 17'd9459;
            4'd12: g = 17'd9088;
            4'd13: g = 17'd8758;
            4'd14: g = 17'd8461;
            4'd15: g = 17'd8192;
        endcase
        return g;
    endfunction

    // saturate to Q1.15
    function automatic logic signed [15:0] sat16(input logic signed [L_W:0] v);
        logic signed [15:0] s;
        if (v > (L_W+1)'(32767))
            s = 16'sh7FFF;
        else if (v < -(L_W+1)'(32768))
            s = 16'sh8000;
        else
            s = v[15:0];
        return s;
    endfunction

endpackage

// File: design/unison_oscillator_mixer.sv
// Unison oscillator mixer: up to VOICES detuned oscillators summed to stereo.
// Channels: input items and results each use valid/ready; a transfer happens
// on a clock edge with both high. Configuration uses cfg_write/cfg_index/
// cfg_data; the user must write it only while the block is idle, which the
// block itself does not enforce. A load voice or note start request
// completes in the accept cycle and keeps in_ready high. A begin block
// request runs one signed division per active voice on the shared 40-step
// bit-serial divider. A sample tick walks the active voices on one shared
// multiplier, with a quarter-sine pass for sine waves and, when N > 1, a pan
// division per voice; the sums are then scaled and delivered, and while the
// click-guard ramp runs, two more divisions are added. A tick with zero
// amplitude and other requests give no result.
// The result sits in an output register; a new item is accepted while it
// waits, and a stalled receiver only holds the block at its final step.
// Reset clears all voice state, the attack counter and the result valid flag,
// and seeds the noise LFSR; registers take their documented defaults.
module unison_oscillator_mixer #(
    parameter int VOICES       = 8,
    parameter int PHASE_BITS   = 24,
    parameter int SINE_ENTRIES = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic [15:0]        envelope_gain,
    input  logic               last_in_block,
    input  logic [12:0]        block_length,
    input  logic [2:0]         voice_index,
    input  logic [23:0]        increment_value,
    input  logic [23:0]        start_phase,
    input  logic               snap,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] left_sample,
    output logic signed [15:0] right_sample,
    output logic signed [15:0] center_sample
);

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int PB = PHASE_BITS;
    localparam int SB = $clog2(SINE_ENTRIES);
    localparam int DW = uom_pkg::DIV_W;
    localparam int AW = uom_pkg::ACC_W;
    localparam int LW = uom_pkg::L_W;

    // configuration
    logic [2:0]  wave_type_reg;
    logic [3:0]  voice_count_reg;
    logic [15:0] amplitude_reg;
    logic [10:0] pan_spread_reg;
    logic [12:0] attack_length_reg;

    // voice state
    logic [PB-1:0]        phase_reg [VOICES];
    logic [PB-1:0]        cur_reg   [VOICES];
    logic [PB-1:0]        tgt_reg   [VOICES];
    logic signed [PB:0]   glide_reg [VOICES];
    logic [12:0]          att_rem_reg;
    logic [31:0]          lfsr_reg;

    // sequencer
    uom_pkg::state_t state_reg, state_next, ret_reg;
    logic [4:0]  v_reg;
    logic [15:0] eg_reg;
    logic        last_reg;
    logic [12:0] bl_reg;

    // per-voice working values
    logic signed [16:0] wav_reg;
    logic signed [17:0] s_reg;
    logic        sine_neg_reg;
    logic [14:0] pan_x_reg;
    logic [15:0] gl_reg, gr_reg;
    logic signed [AW-1:0] lsum_reg, rsum_reg;
    logic signed [LW-1:0] l_reg, r_reg;

    // quarter-sine subroutine
    logic [14:0] qs_x_reg, qs_x2_reg, qs_p_reg;
    logic [13:0] qs_t_reg;
    logic [15:0] qs_y_reg;

    // bit-serial divider
    logic [DW-1:0] div_quo_reg;
    logic [12:0]   div_rem_reg, div_dvs_reg;
    logic          div_neg_reg;
    logic [5:0]    div_cnt_reg;

    // output register
    logic               out_valid_reg;
    logic signed [15:0] left_reg, right_reg, center_reg;

    // derived values
    logic [4:0]  n_act;
    logic [VW-1:0] vi;
    logic [10:0] sp;
    logic signed [6:0] pan_k;
    logic [12:0] att_num;
    logic [31:0] inc_ext, sph_ext;
    logic [PB-1:0] phase_cur;
    logic [31:0] lfsr_step;
    logic [15:0] p16, u16;
    logic [14:0] sin_r;
    logic signed [17:0] tri_a, wave_val;
    logic signed [AW-1:0] mul_a;
    logic signed [17:0]   mul_b;
    logic signed [AW+17:0] mul_p;
    logic signed [DW:0] div_src, div_q;
    logic [12:0] div_dvs_src;
    logic [13:0] rem_sh;
    logic [14:0] rem_dif;
    logic        rem_ge;
    logic [16:0] qs_yq;
    logic signed [LW:0] cen_sum;

    always_comb
    begin
        if (voice_count_reg == 4'd0)
            n_act = 5'd1;
        else if ({1'b0, voice_count_reg} > 5'(VOICES))
            n_act = 5'(VOICES);
        else
            n_act = {1'b0, voice_count_reg};
    end

    assign vi        = v_reg[VW-1:0];
    assign sp        = (pan_spread_reg > 11'd1024) ? 11'd1024 : pan_spread_reg;
    assign pan_k     = $signed({1'b0, v_reg, 1'b0}) - $signed({2'b0, n_act}) + 7'sd1;
    assign att_num   = attack_length_reg - att_rem_reg;
    assign inc_ext   = 32'(increment_value);
    assign sph_ext   = 32'(start_phase);
    assign phase_cur = phase_reg[vi];
    assign lfsr_step = {1'b0, lfsr_reg[31:1]} ^ (lfsr_reg[0] ? uom_pkg::LFSR_TAPS : 32'd0);
    assign p16       = phase_cur[PB-1 -: 16];
    assign u16       = 16'(phase_cur[PB-1 -: SB]) << (16 - SB);
    assign sin_r     = u16[14] ? (15'd16384 - {1'b0, u16[13:0]}) : {1'b0, u16[13:0]};
    assign tri_a     = $signed({2'b0, p16}) - 18'sd32768;

    // non-sine waveforms from the current phase, noise from the LFSR
    always_comb
    begin
        unique case (wave_type_reg)
            uom_pkg::WAVE_SAW:      wave_val = tri_a;
            uom_pkg::WAVE_SQUARE:   wave_val = p16[15] ? -18'sd16384 : 18'sd16384;
            uom_pkg::WAVE_TRIANGLE: wave_val = ((tri_a < 0) ? -tri_a : tri_a) * 2
                                               - 18'sd32768;
            uom_pkg::WAVE_NOISE:    wave_val = $signed({2'b0, lfsr_step[15:0]})
                                               - 18'sd32768;
            default:                wave_val = '0;
        endcase
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            uom_pkg::S_Q1:
            begin
                mul_a = AW'(qs_x_reg);
                mul_b = 18'(qs_x_reg);
            end
            uom_pkg::S_Q2:
            begin
                mul_a = AW'(qs_x2_reg);
                mul_b = 18'(uom_pkg::SIN_C);
            end
            uom_pkg::S_Q3:
            begin
                mul_a = AW'(qs_x2_reg);
                mul_b = 18'(qs_t_reg);
            end
            uom_pkg::S_Q4:
            begin
                mul_a = AW'(qs_x_reg);
                mul_b = 18'(qs_p_reg);
            end
            uom_pkg::S_AMP:
            begin
                mul_a = AW'(wav_reg);
                mul_b = 18'(amplitude_reg);
            end
            uom_pkg::S_PAN:
            begin
                mul_a = AW'(pan_k);
                mul_b = 18'(sp);
            end
            uom_pkg::S_ML:
            begin
                mul_a = AW'(s_reg);
                mul_b = 18'(gl_reg);
            end
            uom_pkg::S_MR:
            begin
                mul_a = AW'(s_reg);
                mul_b = 18'(gr_reg);
            end
            uom_pkg::S_FL:
            begin
                mul_a = lsum_reg;
                mul_b = 18'(uom_pkg::inv_sqrt(4'(n_act - 5'd1)));
            end
            uom_pkg::S_FR:
            begin
                mul_a = rsum_reg;
                mul_b = 18'(uom_pkg::inv_sqrt(4'(n_act - 5'd1)));
            end
            uom_pkg::S_ATT_L:
            begin
                mul_a = AW'(l_reg);
                mul_b = 18'(att_num);
            end
            uom_pkg::S_ATT_R:
            begin
                mul_a = AW'(r_reg);
                mul_b = 18'(att_num);
            end
            uom_pkg::S_ENV_L:
            begin
                mul_a = AW'(l_reg);
                mul_b = 18'(eg_reg);
            end
            uom_pkg::S_ENV_R:
            begin
                mul_a = AW'(r_reg);
                mul_b = 18'(eg_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign qs_yq = 17'(mul_p >>> 13);

    // divider operand select
    always_comb
    begin
        div_src     = '0;
        div_dvs_src = 13'd1;
        unique case (state_reg)
            uom_pkg::S_BB:
            begin
                div_src     = (DW+1)'($signed({1'b0, tgt_reg[vi]}) - $signed({1'b0, cur_reg[vi]}));
                div_dvs_src = bl_reg;
            end
            uom_pkg::S_PAN:
            begin
                div_src     = (DW+1)'(mul_p) <<< 5;
                div_dvs_src = 13'(n_act - 5'd1);
            end
            uom_pkg::S_ATT_L, uom_pkg::S_ATT_R:
            begin
                div_src     = (DW+1)'(mul_p);
                div_dvs_src = attack_length_reg;
            end
            default:
            begin
                div_src     = '0;
                div_dvs_src = 13'd1;
            end
        endcase
    end

    assign rem_sh  = {div_rem_reg, div_quo_reg[DW-1]};
    assign rem_dif = {1'b0, rem_sh} - {2'b0, div_dvs_reg};
    assign rem_ge  = !rem_dif[14];
    assign div_q   = div_neg_reg ? -$signed({1'b0, div_quo_reg}) : $signed({1'b0, div_quo_reg});
    assign cen_sum = (LW+1)'(l_reg) + (LW+1)'(r_reg);

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            uom_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_type == uom_pkg::REQ_BLOCK)
                        state_next = uom_pkg::S_BB;
                    else if (req_type == uom_pkg::REQ_TICK && amplitude_reg != 16'd0)
                        state_next = uom_pkg::S_INC;
                end
            end
            uom_pkg::S_BB:      state_next = uom_pkg::S_DIV;
            uom_pkg::S_BB_WR:   state_next = (v_reg == n_act - 5'd1) ? uom_pkg::S_IDLE
                                                                      : uom_pkg::S_BB;
            uom_pkg::S_INC:     state_next = (wave_type_reg == uom_pkg::WAVE_SINE)
                                             ? uom_pkg::S_Q1 : uom_pkg::S_AMP;
            uom_pkg::S_WAVE:    state_next = uom_pkg::S_AMP;
            uom_pkg::S_AMP:     state_next = (n_act > 5'd1) ? uom_pkg::S_PAN : uom_pkg::S_Q1;
            uom_pkg::S_PAN:     state_next = uom_pkg::S_DIV;
            uom_pkg::S_PAN_WR:  state_next = uom_pkg::S_Q1;
            uom_pkg::S_GR:      state_next = uom_pkg::S_Q1;
            uom_pkg::S_GL:      state_next = uom_pkg::S_ML;
            uom_pkg::S_ML:      state_next = uom_pkg::S_MR;
            uom_pkg::S_MR:      state_next = (v_reg == n_act - 5'd1) ? uom_pkg::S_FL
                                                                      : uom_pkg::S_INC;
            uom_pkg::S_FL:      state_next = uom_pkg::S_FR;
            uom_pkg::S_FR:
            begin
                if (att_rem_reg != 13'd0 && attack_length_reg != 13'd0
                    && att_rem_reg <= attack_length_reg)
                    state_next = uom_pkg::S_ATT_L;
                else
                    state_next = uom_pkg::S_ENV_L;
            end
            uom_pkg::S_ATT_L:    state_next = uom_pkg::S_DIV;
            uom_pkg::S_ATT_L_WR: state_next = uom_pkg::S_ATT_R;
            uom_pkg::S_ATT_R:    state_next = uom_pkg::S_DIV;
            uom_pkg::S_ATT_R_WR: state_next = uom_pkg::S_ENV_L;
            uom_pkg::S_ENV_L:    state_next = uom_pkg::S_ENV_R;
            uom_pkg::S_ENV_R:    state_next = uom_pkg::S_OUT;
            uom_pkg::S_OUT:      state_next = (!out_valid_reg || out_ready) ? uom_pkg::S_IDLE
                                                                            : uom_pkg::S_OUT;
            uom_pkg::S_Q1:       state_next = uom_pkg::S_Q2;
            uom_pkg::S_Q2:       state_next = uom_pkg::S_Q3;
            uom_pkg::S_Q3:       state_next = uom_pkg::S_Q4;
            uom_pkg::S_Q4:       state_next = ret_reg;
            uom_pkg::S_DIV:      state_next = (div_cnt_reg == 6'(DW - 1)) ? ret_reg
                                                                           : uom_pkg::S_DIV;
            default:             state_next = uom_pkg::S_IDLE;
        endcase
    end

    assign in_ready = (state_reg == uom_pkg::S_IDLE);

    // control registers and the output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= uom_pkg::S_IDLE;
            ret_reg           <= uom_pkg::S_IDLE;
            wave_type_reg     <= uom_pkg::WAVE_SINE;
            voice_count_reg   <= 4'd1;
            amplitude_reg     <= 16'd0;
            pan_spread_reg    <= 11'd0;
            attack_length_reg <= 13'd64;
            att_rem_reg       <= 13'd0;
            lfsr_reg          <= uom_pkg::LFSR_SEED;
            v_reg             <= 5'd0;
            div_cnt_reg       <= 6'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // write configuration
            if (cfg_write)
            begin
                unique case (cfg_index)
                    uom_pkg::CFG_WAVE:   wave_type_reg     <= cfg_data[2:0];
                    uom_pkg::CFG_VOICES: voice_count_reg   <= cfg_data[3:0];
                    uom_pkg::CFG_AMP:    amplitude_reg     <= cfg_data;
                    uom_pkg::CFG_SPREAD: pan_spread_reg    <= cfg_data[10:0];
                    uom_pkg::CFG_ATTACK: attack_length_reg <= cfg_data[12:0];
                    default:             ;
                endcase
            end

            // load a new result, or drop the old one once transferred
            if (state_reg == uom_pkg::S_OUT && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                uom_pkg::S_IDLE:
                begin
                    v_reg <= 5'd0;
                    if (in_valid && req_type == uom_pkg::REQ_NOTE)
                        att_rem_reg <= (n_act > 5'd1) ? attack_length_reg : 13'd0;
                end
                uom_pkg::S_BB:
                begin
                    ret_reg     <= uom_pkg::S_BB_WR;
                    div_cnt_reg <= 6'd0;
                end
                uom_pkg::S_BB_WR:
                    v_reg <= v_reg + 5'd1;
                uom_pkg::S_INC:
                begin
                    ret_reg <= uom_pkg::S_WAVE;
                    if (wave_type_reg == uom_pkg::WAVE_NOISE)
                        lfsr_reg <= lfsr_step;
                end
                uom_pkg::S_AMP:
                    ret_reg <= uom_pkg::S_GR;
                uom_pkg::S_PAN:
                begin
                    ret_reg     <= uom_pkg::S_PAN_WR;
                    div_cnt_reg <= 6'd0;
                end
                uom_pkg::S_PAN_WR:
                    ret_reg <= uom_pkg::S_GR;
                uom_pkg::S_GR:
                    ret_reg <= uom_pkg::S_GL;
                uom_pkg::S_MR:
                    v_reg <= v_reg + 5'd1;
                uom_pkg::S_FR:
                begin
                    if (att_rem_reg != 13'd0
                        && (attack_length_reg == 13'd0 || att_rem_reg > attack_length_reg))
                        att_rem_reg <= att_rem_reg - 13'd1;
                end
                uom_pkg::S_ATT_L:
                begin
                    ret_reg     <= uom_pkg::S_ATT_L_WR;
                    div_cnt_reg <= 6'd0;
                end
                uom_pkg::S_ATT_R:
                begin
                    ret_reg     <= uom_pkg::S_ATT_R_WR;
                    div_cnt_reg <= 6'd0;
                end
                uom_pkg::S_ATT_R_WR:
                    att_rem_reg <= att_rem_reg - 13'd1;
                uom_pkg::S_DIV:
                    div_cnt_reg <= div_cnt_reg + 6'd1;
                default:
                    ;
            endcase
        end
    end

    // voice state arrays
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VOICES; i++)
            begin
                phase_reg[i] <= '0;
                cur_reg[i]   <= '0;
                tgt_reg[i]   <= '0;
                glide_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                uom_pkg::S_IDLE:
                begin
                    if (in_valid && req_type == uom_pkg::REQ_LOAD
                        && 32'(voice_index) < VOICES)
                    begin
                        tgt_reg[VW'(voice_index)] <= inc_ext[PB-1:0];
                        if (snap)
                        begin
                            cur_reg[VW'(voice_index)]   <= inc_ext[PB-1:0];
                            phase_reg[VW'(voice_index)] <= sph_ext[PB-1:0];
                        end
                    end
                end
                uom_pkg::S_BB_WR:
                    glide_reg[vi] <= div_q[PB:0];
                uom_pkg::S_INC:
                    cur_reg[vi] <= cur_reg[vi] + glide_reg[vi][PB-1:0];
                uom_pkg::S_MR:
                    phase_reg[vi] <= phase_reg[vi] + cur_reg[vi];
                uom_pkg::S_ENV_R:
                begin
                    if (last_reg)
                    begin
                        for (int i = 0; i < VOICES; i++)
                        begin
                            if (5'(i) < n_act)
                                cur_reg[i] <= tgt_reg[i];
                        end
                    end
                end
                default:
                    ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            uom_pkg::S_IDLE:
            begin
                eg_reg   <= envelope_gain;
                last_reg <= last_in_block;
                bl_reg   <= (block_length == 13'd0) ? 13'd1 : block_length;
                lsum_reg <= '0;
                rsum_reg <= '0;
            end
            uom_pkg::S_BB, uom_pkg::S_PAN, uom_pkg::S_ATT_L, uom_pkg::S_ATT_R:
            begin
                // load the divider with magnitude and sign
                div_neg_reg <= div_src[DW];
                div_quo_reg <= div_src[DW] ? DW'(-div_src) : DW'(div_src);
                div_rem_reg <= '0;
                div_dvs_reg <= div_dvs_src;
            end
            uom_pkg::S_INC:
            begin
                qs_x_reg     <= sin_r;
                sine_neg_reg <= u16[15];
                wav_reg      <= 17'(wave_val);
            end
            uom_pkg::S_WAVE:
                wav_reg <= sine_neg_reg ? -$signed({1'b0, qs_y_reg}) : $signed({1'b0, qs_y_reg});
            uom_pkg::S_AMP:
            begin
                s_reg     <= 18'(mul_p >>> 15);
                pan_x_reg <= 15'd8192;
                qs_x_reg  <= 15'd8192;
            end
            uom_pkg::S_PAN_WR:
            begin
                pan_x_reg <= 15'((div_q + (DW+1)'(32768)) >>> 2);
                qs_x_reg  <= 15'((div_q + (DW+1)'(32768)) >>> 2);
            end
            uom_pkg::S_GR:
            begin
                gr_reg   <= qs_y_reg;
                qs_x_reg <= 15'd16384 - pan_x_reg;
            end
            uom_pkg::S_GL:
                gl_reg <= qs_y_reg;
            uom_pkg::S_ML:
                lsum_reg <= lsum_reg + AW'(mul_p);
            uom_pkg::S_MR:
                rsum_reg <= rsum_reg + AW'(mul_p);
            uom_pkg::S_FL:
                l_reg <= LW'(mul_p >>> 30);
            uom_pkg::S_FR:
            begin
                r_reg <= LW'(mul_p >>> 30);
                // ramp factor is zero for a bad attack setting
                if (att_rem_reg != 13'd0
                    && (attack_length_reg == 13'd0 || att_rem_reg > attack_length_reg))
                begin
                    l_reg <= '0;
                    r_reg <= '0;
                end
            end
            uom_pkg::S_ATT_L_WR:
                l_reg <= LW'(div_q);
            uom_pkg::S_ATT_R_WR:
                r_reg <= LW'(div_q);
            uom_pkg::S_ENV_L:
                l_reg <= LW'(mul_p >>> 15);
            uom_pkg::S_ENV_R:
                r_reg <= LW'(mul_p >>> 15);
            uom_pkg::S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    left_reg   <= uom_pkg::sat16((LW+1)'(l_reg));
                    right_reg  <= uom_pkg::sat16((LW+1)'(r_reg));
                    center_reg <= uom_pkg::sat16(cen_sum >>> 1);
                end
            end
            uom_pkg::S_Q1:
                qs_x2_reg <= 15'(mul_p >>> 14);
            uom_pkg::S_Q2:
                qs_t_reg <= 14'(uom_pkg::SIN_B) - 14'(mul_p >>> 14);
            uom_pkg::S_Q3:
                qs_p_reg <= 15'(uom_pkg::SIN_A) - 15'(mul_p >>> 14);
            uom_pkg::S_Q4:
                qs_y_reg <= (qs_yq > 17'd32767) ? 16'd32767 : qs_yq[15:0];
            uom_pkg::S_DIV:
            begin
                // one quotient bit per cycle
                div_rem_reg <= rem_ge ? rem_dif[12:0] : rem_sh[12:0];
                div_quo_reg <= {div_quo_reg[DW-2:0], rem_ge};
            end
            default:
                ;
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign left_sample   = left_reg;
    assign right_sample  = right_reg;
    assign center_sample = center_reg;

endmodule

// File: design/uom_chk.sv
module uom_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  req_type,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] left_sample,
    input logic [15:0] right_sample,
    input logic [15:0] center_sample
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(left_sample) && $stable(right_sample)
                                    && $stable(center_sample))
        else $error("result changed while stalled");

    // begin block always occupies the sequencer
    a_block_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && req_type == uom_pkg::REQ_BLOCK |=> !in_ready)
        else $error("begin block did not start work");

    // loads and note starts finish in the transfer cycle
    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (req_type == uom_pkg::REQ_LOAD
                                 || req_type == uom_pkg::REQ_NOTE) |=> in_ready)
        else $error("load or note start stalled the input");

    // a new result only follows a busy cycle
    a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without work");

endmodule

bind unison_oscillator_mixer uom_chk u_uom_chk (.*);

// File: dv/unison_oscillator_mixer_test.sv
module unison_oscillator_mixer_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NV = 8;
    localparam int CYCLE_LIMIT = 6000000;

    typedef struct {
        logic [1:0]  req;
        logic [15:0] gain;
        logic        last;
        logic [12:0] blen;
        logic [2:0]  vidx;
        logic [23:0] incr;
        logic [23:0] phase;
        logic        snap;
    } mix_req_t;

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic signed [15:0] center;
    } mix_sample_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [2:0] cfg_index;
    logic [15:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [1:0] req_type;
    logic [15:0] envelope_gain;
    logic last_in_block;
    logic [12:0] block_length;
    logic [2:0] voice_index;
    logic [23:0] increment_value;
    logic [23:0] start_phase;
    logic snap;
    logic out_valid;
    logic out_ready;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic signed [15:0] center_sample;

    // mirrored block state
    logic [2:0]  m_wave;
    logic [3:0]  m_count;
    logic [15:0] m_amp;
    logic [10:0] m_spread;
    logic [12:0] m_attack_len;
    logic [23:0] m_phase [NV];
    logic [23:0] m_cur [NV];
    logic [23:0] m_tgt [NV];
    longint      m_step [NV];
    logic [12:0] m_attack_rem;
    logic [31:0] m_lfsr;

    mix_sample_t expected_samples[$];
    int  fail_count;
    int  idle_pct;
    bit  recv_hold;
    longint cycle_count;

    unison_oscillator_mixer u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .envelope_gain(envelope_gain),
        .last_in_block(last_in_block), .block_length(block_length),
        .voice_index(voice_index), .increment_value(increment_value),
        .start_phase(start_phase), .snap(snap),
        .out_valid(out_valid), .out_ready(out_ready),
        .left_sample(left_sample), .right_sample(right_sample),
        .center_sample(center_sample)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint floor_div_pow2(longint x, int n);
        return x >>> n;
    endfunction

    function automatic longint qsin(longint x);
        longint x2;
        longint p;
        longint y;
        if (x < 0) x = 0;
        if (x > 16384) x = 16384;
        x2 = (x * x) >>> 14;
        p = uom_pkg::SIN_A - ((x2 * (uom_pkg::SIN_B - ((x2 * uom_pkg::SIN_C) >>> 14))) >>> 14);
        y = (x * p) >>> 13;
        return (y > 32767) ? 32767 : y;
    endfunction

    function automatic longint table_sine(logic [23:0] ph);
        longint k;
        longint u;
        longint r;
        longint y;
        int q;
        k = (longint'(ph) * 1024) >> 24;
        u = (k << 16) / 1024;
        q = int'((u >> 14) & 3);
        r = u & 16'h3FFF;
        if (q[0]) r = 16384 - r;
        y = qsin(r);
        return q[1] ? -y : y;
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic int voices_active();
        if (m_count < 1) return 1;
        if (m_count > NV) return NV;
        return int'(m_count);
    endfunction

    // one waveform value; noise advances the LFSR
    function automatic longint voice_wave(logic [23:0] ph);
        longint p16;
        longint a;
        p16 = longint'(ph >> 8);
        case (m_wave)
            uom_pkg::WAVE_SINE:     return table_sine(ph);
            uom_pkg::WAVE_SAW:      return p16 - 32768;
            uom_pkg::WAVE_SQUARE:   return (p16 < 32768) ? 16384 : -16384;
            uom_pkg::WAVE_TRIANGLE:
            begin
                a = p16 - 32768;
                if (a < 0) a = -a;
                return 2 * a - 32768;
            end
            uom_pkg::WAVE_NOISE:
            begin
                m_lfsr = (m_lfsr >> 1) ^ ({32{m_lfsr[0]}} & uom_pkg::LFSR_TAPS);
                return longint'(m_lfsr[15:0]) - 32768;
            end
            default:       return 0;
        endcase
    endfunction

    // advance mirrored state for one request; return 1 with a sample on a tick with nonzero amplitude
    function automatic bit mix_predict(mix_req_t r, output mix_sample_t s);
        int n;
        longint bl;
        longint sp;
        longint eg;
        longint lsum;
        longint rsum;
        longint l;
        longint rr;
        longint w;
        longint pos;
        longint x;
        longint len;
        longint num;
        longint g;
        n = voices_active();
        s = '{0, 0, 0};
        case (r.req)
            uom_pkg::REQ_BLOCK:
            begin
                bl = (r.blen == 0) ? 1 : longint'(r.blen);
                for (int v = 0; v < n; v++)
                    m_step[v] = (longint'(m_tgt[v]) - longint'(m_cur[v])) / bl;
                return 0;
            end
            uom_pkg::REQ_LOAD:
            begin
                m_tgt[r.vidx] = r.incr;
                if (r.snap)
                begin
                    m_cur[r.vidx] = r.incr;
                    m_phase[r.vidx] = r.phase;
                end
                return 0;
            end
            uom_pkg::REQ_NOTE:
            begin
                m_attack_rem = (n > 1) ? m_attack_len : 13'd0;
                return 0;
            end
            default: ;
        endcase
        if (m_amp == 0) return 0;
        eg = longint'(r.gain);
        sp = (m_spread > 1024) ? 1024 : longint'(m_spread);
        lsum = 0;
        rsum = 0;
        for (int v = 0; v < n; v++)
        begin
            m_cur[v] = 24'(longint'(m_cur[v]) + m_step[v]);
            w = floor_div_pow2(voice_wave(m_phase[v]) * longint'(m_amp), 15);
            pos = 32768;
            if (n > 1) pos += ((2 * v - n + 1) * sp * 32) / (n - 1);
            x = pos >>> 2;
            lsum += w * qsin(16384 - x);
            rsum += w * qsin(x);
            m_phase[v] = m_phase[v] + m_cur[v];
        end
        g = longint'(uom_pkg::inv_sqrt(4'(n - 1)));
        l = floor_div_pow2(floor_div_pow2(lsum * g, 15), 15);
        rr = floor_div_pow2(floor_div_pow2(rsum * g, 15), 15);
        if (m_attack_rem > 0)
        begin
            len = longint'(m_attack_len);
            num = len - longint'(m_attack_rem);
            if (len == 0 || num < 0)
            begin
                l = 0;
                rr = 0;
            end
            else
            begin
                l = (l * num) / len;
                rr = (rr * num) / len;
            end
            m_attack_rem--;
        end
        l = floor_div_pow2(l * eg, 15);
        rr = floor_div_pow2(rr * eg, 15);
        if (r.last)
            for (int v = 0; v < n; v++) m_cur[v] = m_tgt[v];
        s.left = 16'(clamp16(l));
        s.right = 16'(clamp16(rr));
        s.center = 16'(clamp16(floor_div_pow2(l + rr, 1)));
        return 1;
    endfunction

    // drop valid for a random number of idle cycles
    task automatic idle_gap();
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // offer one request and wait for its transfer
    task automatic send_request(mix_req_t r);
        mix_sample_t s;
        idle_gap();
        in_valid <= 1'b1;
        req_type <= r.req;
        envelope_gain <= r.gain;
        last_in_block <= r.last;
        block_length <= r.blen;
        voice_index <= r.vidx;
        increment_value <= r.incr;
        start_phase <= r.phase;
        snap <= r.snap;
        do @(posedge clk); while (!in_ready);
        if (mix_predict(r, s)) expected_samples.push_back(s);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            uom_pkg::CFG_WAVE:   m_wave = val[2:0];
            uom_pkg::CFG_VOICES: m_count = val[3:0];
            uom_pkg::CFG_AMP:    m_amp = val;
            uom_pkg::CFG_SPREAD: m_spread = val[10:0];
            uom_pkg::CFG_ATTACK: m_attack_len = val[12:0];
            default: ;
        endcase
    endtask

    // drain pending samples, then let a possible resultless tick finish
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge clk);
        repeat (700) @(posedge clk);
    endtask

    task automatic configure(int wave, int cnt, int amp, int spread, int att);
        settle();
        write_reg(uom_pkg::CFG_WAVE, 16'(wave));
        write_reg(uom_pkg::CFG_VOICES, 16'(cnt));
        write_reg(uom_pkg::CFG_AMP, 16'(amp));
        write_reg(uom_pkg::CFG_SPREAD, 16'(spread));
        write_reg(uom_pkg::CFG_ATTACK, 16'(att));
        cfg_write <= 1'b0;
    endtask

    function automatic mix_req_t tick_req(int gain, bit last);
        mix_req_t r;
        r = '{uom_pkg::REQ_TICK, 16'(gain), last, 13'($urandom_range(8191)),
              3'($urandom_range(7)), 24'($urandom), 24'($urandom), 1'($urandom_range(1))};
        return r;
    endfunction

    function automatic mix_req_t load_req(int idx, int incr, int ph, bit sn);
        mix_req_t r;
        r = '{uom_pkg::REQ_LOAD, 16'($urandom), 1'($urandom_range(1)),
              13'($urandom_range(8191)), 3'(idx), 24'(incr), 24'(ph), sn};
        return r;
    endfunction

    function automatic mix_req_t ctrl_req(logic [1:0] kind, int blen);
        mix_req_t r;
        r = '{kind, 16'($urandom), 1'($urandom_range(1)), 13'(blen), 3'($urandom_range(7)),
              24'($urandom), 24'($urandom), 1'($urandom_range(1))};
        return r;
    endfunction

    // extremes of fields, each request and each special case
    task automatic test_directed();
        configure(uom_pkg::WAVE_SINE, 1, 32768, 0, 64);
        send_request(load_req(0, 8388608, 0, 1));
        send_request(tick_req(32768, 0));
        send_request(tick_req(0, 0));
        send_request(load_req(0, 12345, 24'hFFFFFF, 1));
        send_request(tick_req(65535, 1));
        configure(uom_pkg::WAVE_SAW, 8, 32768, 2047, 0);
        send_request(ctrl_req(uom_pkg::REQ_NOTE, 1));
        send_request(tick_req(32768, 0));
        send_request(load_req(7, 0, 24'h800000, 1));
        send_request(load_req(3, 4000000, 5, 0));
        send_request(ctrl_req(uom_pkg::REQ_BLOCK, 0));
        send_request(tick_req(20000, 0));
        send_request(ctrl_req(uom_pkg::REQ_BLOCK, 8191));
        send_request(tick_req(32768, 1));
        configure(uom_pkg::WAVE_NOISE, 0, 32768, 1024, 4096);
        send_request(ctrl_req(uom_pkg::REQ_NOTE, 1));
        send_request(tick_req(32768, 0));
        configure(7, 15, 0, 512, 8191);
        send_request(tick_req(32768, 0));
        send_request(ctrl_req(uom_pkg::REQ_NOTE, 1));
        configure(5, 3, 65535, 512, 2);
        send_request(tick_req(32768, 0));
        configure(uom_pkg::WAVE_TRIANGLE, 2, 65535, 1024, 1);
        send_request(ctrl_req(uom_pkg::REQ_NOTE, 1));
        send_request(tick_req(65535, 0));
        send_request(tick_req(65535, 0));
    endtask

    // loads, an optional note start, block glide and a run of ticks with random content
    task automatic play_note(int ticks);
        int n;
        n = voices_active();
        for (int v = 0; v < n; v++)
            send_request(load_req(v, $urandom_range(0, 1 << $urandom_range(23)),
                         $urandom, $urandom_range(3) != 0));
        if ($urandom_range(1)) send_request(ctrl_req(uom_pkg::REQ_NOTE, 1));
        send_request(ctrl_req(uom_pkg::REQ_BLOCK, $urandom_range(1, ticks + 2)));
        for (int t = 0; t < ticks; t++)
        begin
            if ($urandom_range(19) == 0)
                send_request(ctrl_req(2'($urandom_range(1, 3)), $urandom_range(8191)));
            send_request(tick_req($urandom_range(0, 65535), t == ticks - 1));
        end
    endtask

    task automatic test_random(int phases);
        int sent;
        for (int ph = 0; ph < phases; ph++)
        begin
            configure($urandom_range(0, 7), $urandom_range(0, 15),
                      ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 65535),
                      $urandom_range(0, 2047), $urandom_range(0, 48));
            idle_pct = (ph % 6 == 5) ? 0 : 28;
            sent = 0;
            while (sent < 60)
            begin
                play_note($urandom_range(4, 14));
                sent += 20;
            end
        end
    endtask

    // hold the receiver so the output register fills and the input stalls
    task automatic test_backpressure();
        configure(uom_pkg::WAVE_SQUARE, 2, 30000, 700, 3);
        idle_pct = 0;
        recv_hold = 1'b1;
        play_note(8);
        recv_hold = 1'b0;
        idle_pct = 28;
    endtask

    // receiver: random stalls and a long hold when asked
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (recv_hold)
            begin
                out_ready <= 1'b0;
                repeat (3000) @(posedge clk);
            end
            out_ready <= (idle_pct == 0) ? 1'b1 : ($urandom_range(99) >= idle_pct);
        end
    end

    // compare each transferred sample with the oldest expectation
    initial
    begin
        mix_sample_t e;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    $error("unexpected sample L=%0d R=%0d C=%0d",
                           left_sample, right_sample, center_sample);
                    fail_count++;
                end
                else
                begin
                    e = expected_samples.pop_front();
                    if (left_sample !== e.left)
                    begin
                        $error("left_sample expected %0d actual %0d", e.left, left_sample);
                        fail_count++;
                    end
                    if (right_sample !== e.right)
                    begin
                        $error("right_sample expected %0d actual %0d", e.right, right_sample);
                        fail_count++;
                    end
                    if (center_sample !== e.center)
                    begin
                        $error("center_sample expected %0d actual %0d",
                               e.center, center_sample);
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("unison_oscillator_mixer regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        req_type = '0;
        envelope_gain = '0;
        last_in_block = 1'b0;
        block_length = 13'd1;
        voice_index = '0;
        increment_value = '0;
        start_phase = '0;
        snap = 1'b0;
        fail_count = 0;
        idle_pct = 28;
        recv_hold = 1'b0;
        m_wave = 0;
        m_count = 1;
        m_amp = 0;
        m_spread = 0;
        m_attack_len = 64;
        for (int v = 0; v < NV; v++)
        begin
            m_phase[v] = 0;
            m_cur[v] = 0;
            m_tgt[v] = 0;
            m_step[v] = 0;
        end
        m_attack_rem = 0;
        m_lfsr = uom_pkg::LFSR_SEED;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random(40);
        settle();
        if (fail_count == 0)
            $display("unison_oscillator_mixer regression: pass");
        else
            $display("unison_oscillator_mixer regression: fail");
        $finish;
    end

endmodule

// File: files.f
design/uom_pkg.sv
design/unison_oscillator_mixer.sv
design/uom_chk.sv
dv/unison_oscillator_mixer_test.sv
